@@ hw/rtl/bde_pkg.sv @@
package bde_pkg;

    localparam int DEPTH_DEF  = 16;
    localparam int DATA_W_DEF = 32;

    localparam int OP_W    = 4;
    localparam int VALUE_W = 32;
    localparam int ARG_W   = 16;
    localparam int ST_W    = 3;
    localparam int NUM_W   = 5;
    localparam int CFG_W   = 5;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_BACK  = 4'd0,
        OP_PUSH_FRONT = 4'd1,
        OP_POP_BACK   = 4'd2,
        OP_POP_FRONT  = 4'd3,
        OP_INSERT     = 4'd4,
        OP_REMOVE     = 4'd5,
        OP_READ       = 4'd6,
        OP_WRITE      = 4'd7,
        OP_DELETE     = 4'd8,
        OP_FIND       = 4'd9,
        OP_COUNT      = 4'd10,
        OP_ROTATE     = 4'd11,
        OP_REVERSE    = 4'd12,
        OP_CLEAR      = 4'd13,
        OP_LENGTH     = 4'd14,
        OP_NONE       = 4'd15
    } t_op;

    typedef enum logic [ST_W-1:0] {
        ST_OK    = 3'd0,
        ST_EMPTY = 3'd1,
        ST_RANGE = 3'd2,
        ST_MISS  = 3'd3,
        ST_FULL  = 3'd4
    } t_status;

    localparam logic CFG_BOUNDED = 1'b0;
    localparam logic CFG_MAX_LEN = 1'b1;

endpackage

@@ hw/rtl/bde_if.sv @@
interface bde_in_if import bde_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [OP_W-1:0]          op;
    logic [VALUE_W-1:0]       value;
    logic signed [ARG_W-1:0]  position_arg;
    logic signed [ARG_W-1:0]  stop_arg;

    modport source (output valid, op, value, position_arg, stop_arg, input ready);
    modport sink (input valid, op, value, position_arg, stop_arg, output ready);
endinterface

interface bde_out_if import bde_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [ST_W-1:0]      status;
    logic [VALUE_W-1:0]   result_value;
    logic [NUM_W-1:0]     result_number;
    logic [NUM_W-1:0]     length;

    modport source (output valid, status, result_value, result_number, length, input ready);
    modport sink (input valid, status, result_value, result_number, length, output ready);
endinterface

@@ hw/rtl/bounded_deque_engine.sv @@
// Double-ended queue of up to DEPTH words in a circular single-port-read RAM, run by a
// small sequencer that takes one request at a time. Push, write, clear and length end
// in the start state; pop and read also pass through a read-data state. Remove, find and
// count read one entry at a time; insert and delete shift one entry at a time; reverse
// swaps one pair at a time; rotate runs a bit-serial modulo and then moves one entry at
// a time, up to length-1 moves. The run time of a request is set by the one RAM read
// port and the serial modulo. While an earlier result is held at the output, the
// sequencer waits in its done state.
module bounded_deque_engine import bde_pkg::*; #(
    parameter int DEPTH  = DEPTH_DEF,
    parameter int DATA_W = DATA_W_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    bde_in_if.sink            i_req,
    bde_out_if.source         o_rsp,
    input  logic              i_cfg_we,
    input  logic              i_cfg_idx,
    input  logic [CFG_W-1:0]  i_cfg_data
);
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = 18;

    typedef enum logic [16:0] {
        S_IDLE  = 17'h00001,
        S_START = 17'h00002,
        S_POPD  = 17'h00004,
        S_SHL   = 17'h00008,
        S_SHLW  = 17'h00010,
        S_SHR   = 17'h00020,
        S_SHRW  = 17'h00040,
        S_SCAN  = 17'h00080,
        S_CMP   = 17'h00100,
        S_DIV   = 17'h00200,
        S_ROT   = 17'h00400,
        S_ROTW  = 17'h00800,
        S_REV   = 17'h01000,
        S_REV1  = 17'h02000,
        S_REV2  = 17'h04000,
        S_REV3  = 17'h08000,
        S_DONE  = 17'h10000
    } t_state;

    t_state r_state, n_state;
    logic [AW-1:0] r_head, n_head;
    logic [CW-1:0] r_cnt, n_cnt;
    logic r_bounded;
    logic [CFG_W-1:0] r_max_len;
    logic r_ovalid, n_ovalid;

    t_op r_op, n_op;
    logic [DATA_W-1:0] r_val, n_val;
    logic signed [ARG_W-1:0] r_pos, n_pos, r_stop, n_stop;
    logic [CW-1:0] r_i, n_i, r_end, n_end, r_num, n_num;
    t_status r_status, n_status;
    logic [VALUE_W-1:0] r_rv, n_rv;
    logic [DATA_W-1:0] r_tmp, n_tmp;
    logic [ARG_W-1:0] r_dvd, n_dvd;
    logic [3:0] r_bit, n_bit;
    logic r_dir, n_dir;
    logic [ST_W-1:0] r_o_status, n_o_status;
    logic [VALUE_W-1:0] r_o_rv, n_o_rv;
    logic [NUM_W-1:0] r_o_num, n_o_num, r_o_len, n_o_len;

    logic ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [DATA_W-1:0] ram_wdata, ram_rdata;

    bde_ram #(.W(DATA_W), .D(DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] h, input logic [CW-1:0] i);
        logic [CW:0] s;
        s = (CW+1)'(h) + (CW+1)'(i);
        if (s >= (CW+1)'(DEPTH)) begin
            s = s - (CW+1)'(DEPTH);
        end
        return s[AW-1:0];
    endfunction

    function automatic logic [AW-1:0] inc_ptr(input logic [AW-1:0] h);
        return (h == AW'(DEPTH - 1)) ? '0 : h + AW'(1);
    endfunction

    function automatic logic [AW-1:0] dec_ptr(input logic [AW-1:0] h);
        return (h == '0) ? AW'(DEPTH - 1) : h - AW'(1);
    endfunction

    function automatic logic [VALUE_W-1:0] to_word(input logic [DATA_W-1:0] d);
        logic [DATA_W+VALUE_W-1:0] w;
        w = {{VALUE_W{1'b0}}, d};
        return w[VALUE_W-1:0];
    endfunction

    function automatic logic [NUM_W-1:0] to_num(input logic [CW-1:0] c);
        logic [CW+NUM_W-1:0] w;
        w = {{NUM_W{1'b0}}, c};
        return w[NUM_W-1:0];
    endfunction

    logic cnt_eq_max;
    logic signed [IW-1:0] n_s, pos_s, stop_s, p_adj, st_adj;
    logic [CW:0] rem2;

    assign cnt_eq_max = ({{CFG_W{1'b0}}, r_cnt} == {{CW{1'b0}}, r_max_len});
    assign n_s    = signed'(IW'(r_cnt));
    assign pos_s  = IW'(r_pos);
    assign stop_s = IW'(r_stop);
    assign rem2   = {r_i, r_dvd[ARG_W-1]};

    always_comb begin
        logic [AW-1:0] h1;
        logic [CW-1:0] c1;
        logic [DATA_W+VALUE_W-1:0] vw;
        n_state = r_state;
        n_head = r_head;
        n_cnt = r_cnt;
        n_ovalid = r_ovalid;
        n_op = r_op;
        n_val = r_val;
        n_pos = r_pos;
        n_stop = r_stop;
        n_i = r_i;
        n_end = r_end;
        n_num = r_num;
        n_status = r_status;
        n_rv = r_rv;
        n_tmp = r_tmp;
        n_dvd = r_dvd;
        n_bit = r_bit;
        n_dir = r_dir;
        n_o_status = r_o_status;
        n_o_rv = r_o_rv;
        n_o_num = r_o_num;
        n_o_len = r_o_len;
        ram_we = 1'b0;
        ram_waddr = '0;
        ram_wdata = r_val;
        ram_raddr = '0;
        h1 = r_head;
        c1 = r_cnt;
        p_adj = '0;
        st_adj = '0;
        vw = {{DATA_W{1'b0}}, i_req.value};

        if (r_ovalid && o_rsp.ready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_op = t_op'(i_req.op);
                    n_val = vw[DATA_W-1:0];
                    n_pos = i_req.position_arg;
                    n_stop = i_req.stop_arg;
                    n_state = S_START;
                end
            end
            S_START: begin
                n_status = ST_OK;
                n_rv = '0;
                n_num = '0;
                n_state = S_DONE;
                p_adj = (pos_s < 0) ? pos_s + n_s : pos_s;
                case (r_op)
                    OP_PUSH_BACK, OP_PUSH_FRONT: begin
                        if (!(r_bounded && r_max_len == '0)) begin
                            if (r_bounded && cnt_eq_max) begin
                                c1 = r_cnt - CW'(1);
                                if (r_op == OP_PUSH_BACK) begin
                                    h1 = inc_ptr(r_head);
                                end
                            end
                            n_head = h1;
                            n_cnt = c1;
                            if (c1 >= CW'(DEPTH)) begin
                                n_status = ST_FULL;
                            end else if (r_op == OP_PUSH_FRONT) begin
                                ram_we = 1'b1;
                                ram_waddr = dec_ptr(h1);
                                n_head = dec_ptr(h1);
                                n_cnt = c1 + CW'(1);
                            end else begin
                                ram_we = 1'b1;
                                ram_waddr = slot_of(h1, c1);
                                n_cnt = c1 + CW'(1);
                            end
                        end
                    end
                    OP_POP_BACK, OP_POP_FRONT: begin
                        if (r_cnt == '0) begin
                            n_status = ST_EMPTY;
                        end else begin
                            n_cnt = r_cnt - CW'(1);
                            n_state = S_POPD;
                            if (r_op == OP_POP_BACK) begin
                                ram_raddr = slot_of(r_head, r_cnt - CW'(1));
                            end else begin
                                ram_raddr = r_head;
                                n_head = inc_ptr(r_head);
                            end
                        end
                    end
                    OP_INSERT: begin
                        if (r_bounded && cnt_eq_max) begin
                            n_status = ST_RANGE;
                        end else if (r_cnt >= CW'(DEPTH)) begin
                            n_status = ST_FULL;
                        end else begin
                            if (p_adj < 0) begin
                                p_adj = '0;
                            end
                            if (p_adj > n_s) begin
                                p_adj = n_s;
                            end
                            n_end = CW'(p_adj);
                            n_i = r_cnt;
                            n_state = S_SHR;
                        end
                    end
                    OP_READ, OP_WRITE, OP_DELETE: begin
                        if (p_adj < 0 || p_adj >= n_s) begin
                            n_status = ST_RANGE;
                        end else if (r_op == OP_READ) begin
                            ram_raddr = slot_of(r_head, CW'(p_adj));
                            n_state = S_POPD;
                        end else if (r_op == OP_WRITE) begin
                            ram_we = 1'b1;
                            ram_waddr = slot_of(r_head, CW'(p_adj));
                        end else begin
                            n_i = CW'(p_adj);
                            n_state = S_SHL;
                        end
                    end
                    OP_REMOVE, OP_COUNT: begin
                        n_status = (r_op == OP_REMOVE) ? ST_MISS : ST_OK;
                        n_i = '0;
                        n_end = r_cnt;
                        n_state = S_SCAN;
                    end
                    OP_FIND: begin
                        if (p_adj < 0) begin
                            p_adj = '0;
                        end
                        st_adj = (stop_s < 0) ? stop_s + n_s : stop_s;
                        if (st_adj < 0) begin
                            st_adj = '0;
                        end
                        if (st_adj > n_s) begin
                            st_adj = n_s;
                        end
                        if (p_adj > st_adj) begin
                            p_adj = st_adj;
                        end
                        n_status = ST_MISS;
                        n_i = CW'(p_adj);
                        n_end = CW'(st_adj);
                        n_state = S_SCAN;
                    end
                    OP_ROTATE: begin
                        if (r_pos != '0 && r_cnt != '0) begin
                            n_dvd = r_pos[ARG_W-1] ? (~r_pos + ARG_W'(1)) : r_pos;
                            n_dir = !r_pos[ARG_W-1];
                            n_i = '0;
                            n_bit = '0;
                            n_state = S_DIV;
                        end
                    end
                    OP_REVERSE: begin
                        if (r_cnt > CW'(1)) begin
                            n_i = '0;
                            n_end = r_cnt - CW'(1);
                            n_state = S_REV;
                        end
                    end
                    OP_CLEAR: begin
                        n_cnt = '0;
                        n_head = '0;
                    end
                    default: begin
                    end
                endcase
            end
            S_POPD: begin
                n_rv = to_word(ram_rdata);
                n_state = S_DONE;
            end
            S_SHL: begin
                if (r_i + CW'(1) < r_cnt) begin
                    ram_raddr = slot_of(r_head, r_i + CW'(1));
                    n_state = S_SHLW;
                end else begin
                    n_cnt = r_cnt - CW'(1);
                    n_state = S_DONE;
                end
            end
            S_SHLW: begin
                ram_we = 1'b1;
                ram_waddr = slot_of(r_head, r_i);
                ram_wdata = ram_rdata;
                n_i = r_i + CW'(1);
                n_state = S_SHL;
            end
            S_SHR: begin
                if (r_i > r_end) begin
                    ram_raddr = slot_of(r_head, r_i - CW'(1));
                    n_state = S_SHRW;
                end else begin
                    ram_we = 1'b1;
                    ram_waddr = slot_of(r_head, r_end);
                    n_cnt = r_cnt + CW'(1);
                    n_state = S_DONE;
                end
            end
            S_SHRW: begin
                ram_we = 1'b1;
                ram_waddr = slot_of(r_head, r_i);
                ram_wdata = ram_rdata;
                n_i = r_i - CW'(1);
                n_state = S_SHR;
            end
            S_SCAN: begin
                if (r_i < r_end) begin
                    ram_raddr = slot_of(r_head, r_i);
                    n_state = S_CMP;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_CMP: begin
                n_state = S_SCAN;
                n_i = r_i + CW'(1);
                if (ram_rdata == r_val) begin
                    if (r_op == OP_REMOVE) begin
                        n_status = ST_OK;
                        n_i = r_i;
                        n_state = S_SHL;
                    end else if (r_op == OP_FIND) begin
                        n_status = ST_OK;
                        n_num = r_i;
                        n_state = S_DONE;
                    end else begin
                        n_num = r_num + CW'(1);
                    end
                end
            end
            S_DIV: begin
                n_i = (rem2 >= {1'b0, r_cnt}) ? CW'(rem2 - {1'b0, r_cnt}) : CW'(rem2);
                n_dvd = r_dvd << 1;
                n_bit = r_bit + 4'd1;
                if (r_bit == 4'd15) begin
                    n_state = S_ROT;
                end
            end
            S_ROT: begin
                if (r_i != '0) begin
                    ram_raddr = r_dir ? slot_of(r_head, r_cnt - CW'(1)) : r_head;
                    n_state = S_ROTW;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_ROTW: begin
                ram_we = 1'b1;
                ram_wdata = ram_rdata;
                if (r_dir) begin
                    ram_waddr = dec_ptr(r_head);
                    n_head = dec_ptr(r_head);
                end else begin
                    ram_waddr = slot_of(r_head, r_cnt);
                    n_head = inc_ptr(r_head);
                end
                n_i = r_i - CW'(1);
                n_state = S_ROT;
            end
            S_REV: begin
                if (r_i < r_end) begin
                    ram_raddr = slot_of(r_head, r_i);
                    n_state = S_REV1;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_REV1: begin
                n_tmp = ram_rdata;
                ram_raddr = slot_of(r_head, r_end);
                n_state = S_REV2;
            end
            S_REV2: begin
                ram_we = 1'b1;
                ram_waddr = slot_of(r_head, r_i);
                ram_wdata = ram_rdata;
                n_state = S_REV3;
            end
            S_REV3: begin
                ram_we = 1'b1;
                ram_waddr = slot_of(r_head, r_end);
                ram_wdata = r_tmp;
                n_i = r_i + CW'(1);
                n_end = r_end - CW'(1);
                n_state = S_REV;
            end
            S_DONE: begin
                if (!r_ovalid || o_rsp.ready) begin
                    n_ovalid = 1'b1;
                    n_o_status = r_status;
                    n_o_rv = r_rv;
                    n_o_num = to_num(r_num);
                    n_o_len = to_num(r_cnt);
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head <= '0;
            r_cnt <= '0;
            r_bounded <= 1'b0;
            r_max_len <= CFG_W'(16);
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head <= n_head;
            r_cnt <= n_cnt;
            r_ovalid <= n_ovalid;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_BOUNDED: r_bounded <= i_cfg_data[0];
                    CFG_MAX_LEN: r_max_len <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op <= n_op;
        r_val <= n_val;
        r_pos <= n_pos;
        r_stop <= n_stop;
        r_i <= n_i;
        r_end <= n_end;
        r_num <= n_num;
        r_status <= n_status;
        r_rv <= n_rv;
        r_tmp <= n_tmp;
        r_dvd <= n_dvd;
        r_bit <= n_bit;
        r_dir <= n_dir;
        r_o_status <= n_o_status;
        r_o_rv <= n_o_rv;
        r_o_num <= n_o_num;
        r_o_len <= n_o_len;
    end

    assign i_req.ready = (r_state == S_IDLE);
    assign o_rsp.valid = r_ovalid;
    assign o_rsp.status = r_o_status;
    assign o_rsp.result_value = r_o_rv;
    assign o_rsp.result_number = r_o_num;
    assign o_rsp.length = r_o_len;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(DEPTH)) else $error("item count above store depth");
    a_head_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head < AW'(DEPTH - 1) || r_head == AW'(DEPTH - 1)) else $error("head out of range");
    a_accept_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> r_state == S_START) else $error("request not started");
    a_done_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_ovalid && !o_rsp.ready) |=> r_state == S_DONE)
        else $error("result left while output blocked");
endmodule

@@ hw/rtl/bde_ram.sv @@
module bde_ram #(
    parameter int W = 32,
    parameter int D = 16
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);
    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule
